// ----- hdl/vdp_pkg.sv -----
`timescale 1ns / 1ps

package vdp_pkg;

  localparam int MEM_DEPTH = 16384;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  // raw address from the control sequence is 14 bits before wrapping
  localparam int RAW_W      = 14;
  localparam int RAW_SPAN   = 1 << RAW_W;
  localparam int WRAP_W     = ((RAW_W > ADDR_W) ? RAW_W : ADDR_W) + 1;
  localparam int LOAD_FOLDS = (RAW_SPAN + MEM_DEPTH - 1) / MEM_DEPTH;

  localparam int ACT_W  = 2;
  localparam int BYTE_W = 8;
  localparam int NREGS  = 8;
  localparam int REG_W  = $clog2(NREGS);

  localparam logic [ACT_W-1:0] ACT_READ  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_WRITE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_TICK  = 2'd2;

  localparam logic PORT_DATA = 1'b0;
  localparam logic PORT_CTRL = 1'b1;

  localparam logic [REG_W-1:0] REG_MODE1 = 3'd1;

  localparam logic [BYTE_W-1:0] STATUS_KEEP = 8'h1f;
  localparam logic [BYTE_W-1:0] STATUS_FRAME = 8'h80;

  localparam int BIT_FRAME  = 7;
  localparam int BIT_IRQ_EN = 5;
  localparam int BIT_REG_WR = 7;
  localparam int BIT_WR_MODE = 6;

  localparam logic [BYTE_W-1:0] REG_MASK [NREGS] = '{
    8'h03, 8'hfb, 8'h0f, 8'hff, 8'h07, 8'h7f, 8'h07, 8'hff
  };

  typedef struct packed {
    logic clear;
    logic accept;
    logic exec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
  } dp_status_t;

  function automatic logic [ADDR_W-1:0] addr_step(input logic [ADDR_W-1:0] a);
    return (a == ADDR_W'(MEM_DEPTH - 1)) ? '0 : a + 1'b1;
  endfunction

  function automatic logic [ADDR_W-1:0] wrap_load(input logic [RAW_W-1:0] raw);
    logic [WRAP_W-1:0] w;
    w = WRAP_W'(raw);
    for (int i = 0; i < LOAD_FOLDS; i++) begin
      if (w >= WRAP_W'(MEM_DEPTH)) w = w - WRAP_W'(MEM_DEPTH);
    end
    return w[ADDR_W-1:0];
  endfunction

endpackage

// ----- hdl/vdp_ifs.sv -----
`timescale 1ns / 1ps

interface vdp_in_if import vdp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic              port_select;
  logic [BYTE_W-1:0] write_data;

  modport source (output valid, action, port_select, write_data, input ready);
  modport sink   (input valid, action, port_select, write_data, output ready);
endinterface

interface vdp_out_if import vdp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] read_data;
  logic              irq_level;

  modport source (output valid, read_data, irq_level, input ready);
  modport sink   (input valid, read_data, irq_level, output ready);
endinterface

// ----- hdl/vdp_cpu_port_interface_core.sv -----
`timescale 1ns / 1ps
// channel  role  payload
// -------  ----  -----------------------------------------
// cpu      sink  action[1:0], port_select, write_data[7:0]
// result   src   read_data[7:0], irq_level
//
// Accept issues the video memory read for each word; the finishing step in
// S_EXEC then gets the registered read data, updates state and any memory store.
// After reset a clearing pass writes zero to all MEM_DEPTH (16384) entries,
// one a cycle, before the first word is accepted.
// A stalled result holds the finishing step; the next word is still taken
// while a finished result waits in the output register.

module vdp_cpu_port_interface_core import vdp_pkg::*; (
  input logic       clk,
  input logic       rst,
  vdp_in_if.sink    cpu,
  vdp_out_if.source result
);

  ctrl_cmd_t  cmd;
  dp_status_t dp_st;

  vdp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cpu.valid),
    .in_ready  (cpu.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (dp_st),
    .cmd       (cmd)
  );

  vdp_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (dp_st),
    .action      (cpu.action),
    .port_select (cpu.port_select),
    .write_data  (cpu.write_data),
    .read_data   (result.read_data),
    .irq_level   (result.irq_level)
  );

endmodule

// ----- hdl/vdp_ram.sv -----
`timescale 1ns / 1ps

module vdp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) mem[addr] <= wdata;
      else    rdata     <= mem[addr];
    end
  end

endmodule

// ----- hdl/vdp_ctrl.sv -----
`timescale 1ns / 1ps

module vdp_ctrl import vdp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;

  assign cmd.clear  = (state == S_CLEAR);
  assign cmd.accept = in_ready && in_valid;
  // finish only when the result register is free or being emptied
  assign cmd.exec   = (state == S_EXEC) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      in_ready  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.exec)                    out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          if (status.clear_last) begin
            state    <= S_IDLE;
            in_ready <= 1'b1;
          end
        end
        S_IDLE: begin
          if (cmd.accept) begin
            state    <= S_EXEC;
            in_ready <= 1'b0;
          end
        end
        S_EXEC: begin
          if (cmd.exec) begin
            state    <= S_IDLE;
            in_ready <= 1'b1;
          end
        end
      endcase
    end
  end

endmodule

// ----- hdl/vdp_dp.sv -----
`timescale 1ns / 1ps

module vdp_dp import vdp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  ctrl_cmd_t         cmd,
  output dp_status_t        status,
  input  logic [ACT_W-1:0]  action,
  input  logic              port_select,
  input  logic [BYTE_W-1:0] write_data,
  output logic [BYTE_W-1:0] read_data,
  output logic              irq_level
);

  logic [ADDR_W-1:0] clr_addr;

  logic [ADDR_W-1:0] mem_ptr, mem_ptr_next;
  logic              write_mode, write_mode_next;
  logic              first_byte, first_byte_next;
  logic [BYTE_W-1:0] latch_byte, latch_byte_next;
  logic [BYTE_W-1:0] read_ahead, read_ahead_next;
  logic [BYTE_W-1:0] status_reg, status_reg_next;
  logic [BYTE_W-1:0] ctrl_regs [NREGS];
  logic [BYTE_W-1:0] ctrl_regs_next [NREGS];
  logic              irq, irq_next;
  logic [BYTE_W-1:0] rd_next;

  logic [ACT_W-1:0]  item_act;
  logic              item_port;
  logic [BYTE_W-1:0] item_val;

  logic              ram_en, ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [BYTE_W-1:0] ram_wdata, ram_rdata;

  logic [ADDR_W-1:0] in_load_addr, item_load_addr, addr_inc;
  logic              in_is_load;
  logic [REG_W-1:0]  reg_sel;
  logic [BYTE_W-1:0] reg_val;
  logic              item_mem_wr;

  vdp_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign status.clear_last = (clr_addr == ADDR_W'(MEM_DEPTH - 1));

  assign in_load_addr   = wrap_load({write_data[5:0], latch_byte});
  assign item_load_addr = wrap_load({item_val[5:0], latch_byte});
  assign addr_inc       = addr_step(mem_ptr);
  assign in_is_load     = (action == ACT_WRITE) && (port_select == PORT_CTRL) &&
                          !first_byte && !write_data[BIT_REG_WR];
  assign reg_sel        = item_val[REG_W-1:0];
  assign reg_val        = latch_byte & REG_MASK[reg_sel];
  assign item_mem_wr    = (item_act == ACT_WRITE) && (item_port == PORT_DATA);

  // zero on clear, prefetch on accept, store on finish
  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = mem_ptr;
    ram_wdata = item_val;
    priority if (cmd.clear) begin
      ram_en    = 1'b1;
      ram_we    = 1'b1;
      ram_addr  = clr_addr;
      ram_wdata = '0;
    end else if (cmd.accept) begin
      ram_en   = 1'b1;
      ram_addr = in_is_load ? in_load_addr : mem_ptr;
    end else if (cmd.exec && item_mem_wr) begin
      ram_en   = 1'b1;
      ram_we   = 1'b1;
      // read mode stores at the stepped address
      ram_addr = write_mode ? mem_ptr : addr_inc;
    end
  end

  always_comb begin
    mem_ptr_next    = mem_ptr;
    write_mode_next = write_mode;
    first_byte_next = first_byte;
    latch_byte_next = latch_byte;
    read_ahead_next = read_ahead;
    status_reg_next = status_reg;
    ctrl_regs_next  = ctrl_regs;
    irq_next        = irq;
    rd_next         = '0;
    unique case (item_act)
      ACT_READ: begin
        first_byte_next = 1'b1;
        if (item_port == PORT_CTRL) begin
          rd_next         = status_reg;
          status_reg_next = status_reg & STATUS_KEEP;
          irq_next        = 1'b0;
        end else begin
          rd_next         = read_ahead;
          read_ahead_next = ram_rdata;
          mem_ptr_next    = addr_inc;
        end
      end
      ACT_WRITE: begin
        if (item_port == PORT_CTRL) begin
          if (first_byte) begin
            first_byte_next = 1'b0;
            latch_byte_next = item_val;
          end else begin
            first_byte_next = 1'b1;
            if (item_val[BIT_REG_WR]) begin
              ctrl_regs_next[reg_sel] = reg_val;
              if (reg_sel == REG_MODE1 && status_reg[BIT_FRAME])
                irq_next = reg_val[BIT_IRQ_EN];
            end else begin
              write_mode_next = item_val[BIT_WR_MODE];
              if (item_val[BIT_WR_MODE]) begin
                mem_ptr_next = item_load_addr;
              end else begin
                read_ahead_next = ram_rdata;
                mem_ptr_next    = addr_step(item_load_addr);
              end
            end
          end
        end else begin
          first_byte_next = 1'b1;
          read_ahead_next = write_mode ? item_val : ram_rdata;
          mem_ptr_next    = addr_inc;
        end
      end
      ACT_TICK: begin
        status_reg_next = status_reg | STATUS_FRAME;
        if (ctrl_regs[REG_MODE1][BIT_IRQ_EN]) irq_next = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr   <= '0;
      mem_ptr    <= '0;
      write_mode <= 1'b0;
      first_byte <= 1'b0;
      latch_byte <= '0;
      read_ahead <= '0;
      status_reg <= '0;
      ctrl_regs  <= '{default: '0};
      irq        <= 1'b0;
    end else begin
      if (cmd.clear) clr_addr <= clr_addr + 1'b1;
      if (cmd.exec) begin
        mem_ptr    <= mem_ptr_next;
        write_mode <= write_mode_next;
        first_byte <= first_byte_next;
        latch_byte <= latch_byte_next;
        read_ahead <= read_ahead_next;
        status_reg <= status_reg_next;
        ctrl_regs  <= ctrl_regs_next;
        irq        <= irq_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_act  <= action;
      item_port <= port_select;
      item_val  <= write_data;
    end
    if (cmd.exec) begin
      read_data <= rd_next;
      irq_level <= irq_next;
    end
  end

endmodule

// ----- verif/vdp_port_checker.sv -----
`timescale 1ns / 1ps

module vdp_port_checker import vdp_pkg::*; (
  input  logic clk,
  input  logic rst,
  vdp_in_if    cpu_mon,
  vdp_out_if   result_mon,
  output int   fail_count,
  output int   pending,
  output int   results_seen
);

  typedef struct packed {
    logic [BYTE_W-1:0] read_data;
    logic              irq_level;
  } port_reply_t;

  port_reply_t replies_due[$];

  logic [BYTE_W-1:0] vram [MEM_DEPTH];
  logic [BYTE_W-1:0] vdp_regs [NREGS];
  logic [ADDR_W-1:0] vram_ptr;
  logic              write_mode;
  logic              want_first;
  logic [BYTE_W-1:0] latch_byte;
  logic [BYTE_W-1:0] prefetch;
  logic [BYTE_W-1:0] status_byte;
  logic              irq_line;

  function automatic logic [ADDR_W-1:0] next_addr(input logic [ADDR_W-1:0] a);
    return ADDR_W'((int'(a) + 1) % MEM_DEPTH);
  endfunction

  // Apply one bus word to the shadow state and return the reply it produces.
  function automatic port_reply_t bus_access(input logic [ACT_W-1:0] act, input logic port,
                                             input logic [BYTE_W-1:0] val);
    port_reply_t       reply;
    logic [REG_W-1:0]  idx;
    logic [BYTE_W-1:0] masked;
    reply.read_data = '0;
    case (act)
      ACT_READ: begin
        want_first = 1'b1;
        if (port == PORT_CTRL) begin
          reply.read_data = status_byte;
          status_byte &= STATUS_KEEP;
          irq_line = 1'b0;
        end else begin
          reply.read_data = prefetch;
          prefetch = vram[vram_ptr];
          vram_ptr = next_addr(vram_ptr);
        end
      end
      ACT_WRITE: begin
        if (port == PORT_CTRL) begin
          if (want_first) begin
            want_first = 1'b0;
            latch_byte = val;
          end else begin
            want_first = 1'b1;
            if (val[BIT_REG_WR]) begin
              idx = val[REG_W-1:0];
              masked = latch_byte & REG_MASK[idx];
              vdp_regs[idx] = masked;
              // interrupt follows the new enable only while a frame is flagged
              if (idx == REG_MODE1 && status_byte[BIT_FRAME]) irq_line = masked[BIT_IRQ_EN];
            end else begin
              vram_ptr = ADDR_W'(int'({val[RAW_W-BYTE_W-1:0], latch_byte}) % MEM_DEPTH);
              write_mode = val[BIT_WR_MODE];
              if (!write_mode) begin
                prefetch = vram[vram_ptr];
                vram_ptr = next_addr(vram_ptr);
              end
            end
          end
        end else begin
          want_first = 1'b1;
          if (write_mode) begin
            vram[vram_ptr] = val;
            prefetch = val;
            vram_ptr = next_addr(vram_ptr);
          end else begin
            // read mode: fetch ahead, step, then store at the new address
            prefetch = vram[vram_ptr];
            vram_ptr = next_addr(vram_ptr);
            vram[vram_ptr] = val;
          end
        end
      end
      ACT_TICK: begin
        status_byte |= STATUS_FRAME;
        if (vdp_regs[REG_MODE1][BIT_IRQ_EN]) irq_line = 1'b1;
      end
      default: ;
    endcase
    reply.irq_level = irq_line;
    return reply;
  endfunction

  always @(posedge clk) begin : check_results
    port_reply_t want;
    if (rst) begin
      foreach (vram[i]) vram[i] = '0;
      foreach (vdp_regs[i]) vdp_regs[i] = '0;
      vram_ptr     = '0;
      write_mode   = 1'b0;
      want_first   = 1'b0;
      latch_byte   = '0;
      prefetch     = '0;
      status_byte  = '0;
      irq_line     = 1'b0;
      replies_due.delete();
      fail_count   = 0;
      results_seen = 0;
    end else begin
      if (cpu_mon.valid && cpu_mon.ready)
        replies_due.push_back(bus_access(cpu_mon.action, cpu_mon.port_select,
                                         cpu_mon.write_data));
      if (result_mon.valid && result_mon.ready) begin
        results_seen++;
        if (replies_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result word: read_data %02h irq_level %0b",
                     result_mon.read_data, result_mon.irq_level);
        end else begin
          want = replies_due.pop_front();
          if (result_mon.read_data !== want.read_data ||
              result_mon.irq_level !== want.irq_level) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result %0d mismatch: expected read_data %02h irq_level %0b, got %02h %0b",
                       results_seen, want.read_data, want.irq_level,
                       result_mon.read_data, result_mon.irq_level);
          end
        end
      end
    end
    pending = replies_due.size();
  end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import vdp_pkg::*;

  localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;
  localparam logic [REG_W-1:0] REG_LAST  = REG_W'(NREGS - 1);
  localparam int TOTAL_WORDS = 800;
  localparam int CYCLE_LIMIT = 400000;
  localparam int IDLE_PCT    = 38;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic calm = 1'b0;
  logic first_byte_next = 1'b0;  // block takes the next control write as a first byte
  logic held = 1'b0;
  int   cycles = 0;
  int   fail_count, pending, results_seen;
  int   words_sent = 0;
  int   n_data_rd = 0, n_status_rd = 0, n_data_wr = 0, n_ctrl_wr = 0, n_ticks = 0, n_spare = 0;
  int   roll;

  vdp_in_if  cpu ();
  vdp_out_if result ();

  vdp_cpu_port_interface_core dut (
    .clk(clk),
    .rst(rst),
    .cpu(cpu),
    .result(result)
  );

  vdp_port_checker chk (
    .clk(clk),
    .rst(rst),
    .cpu_mon(cpu),
    .result_mon(result),
    .fail_count(fail_count),
    .pending(pending),
    .results_seen(results_seen)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) result.ready <= calm || ($urandom_range(99) >= IDLE_PCT);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timed out after %0d cycles with %0d words outstanding", cycles, pending);
      $display("vdp_cpu_port_interface_core verification failed");
      $finish;
    end
  end

  task automatic send_word(input logic [ACT_W-1:0] act, input logic port,
                           input logic [BYTE_W-1:0] val);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      cpu.valid <= 1'b0;
      @(negedge clk);
    end
    cpu.valid       <= 1'b1;
    cpu.action      <= act;
    cpu.port_select <= port;
    cpu.write_data  <= val;
    @(posedge clk);
    while (!cpu.ready) @(posedge clk);
    @(negedge clk);
    case (act)
      ACT_READ: begin
        first_byte_next = 1'b1;
        if (port == PORT_CTRL) n_status_rd++;
        else n_data_rd++;
      end
      ACT_WRITE: begin
        if (port == PORT_CTRL) begin
          first_byte_next = !first_byte_next;
          n_ctrl_wr++;
        end else begin
          first_byte_next = 1'b1;
          n_data_wr++;
        end
      end
      ACT_TICK: n_ticks++;
      default: n_spare++;
    endcase
    words_sent++;
  endtask

  // Send a control byte pair, first resyncing with a status read if the block is waiting for a second byte.
  task automatic ctrl_pair(input logic [BYTE_W-1:0] lo, input logic [BYTE_W-1:0] hi);
    if (!first_byte_next) send_word(ACT_READ, PORT_CTRL, BYTE_W'($urandom));
    send_word(ACT_WRITE, PORT_CTRL, lo);
    send_word(ACT_WRITE, PORT_CTRL, hi);
  endtask

  task automatic set_address(input logic [RAW_W-1:0] a, input logic wmode);
    ctrl_pair(a[BYTE_W-1:0], {1'b0, wmode, a[RAW_W-1:BYTE_W]});
  endtask

  task automatic set_register(input logic [REG_W-1:0] idx, input logic [BYTE_W-1:0] value);
    ctrl_pair(value, {1'b1, 4'($urandom), idx});
  endtask

  task automatic data_burst();
    int n;
    n = $urandom_range(6, 1);
    repeat (n) begin
      if ($urandom_range(1)) send_word(ACT_WRITE, PORT_DATA, BYTE_W'($urandom));
      else send_word(ACT_READ, PORT_DATA, BYTE_W'($urandom));
    end
  endtask

  // Hold the bus until every word in flight has been answered.
  task automatic drain();
    cpu.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // Mostly small windows at both ends so reads hit bytes written earlier.
  function automatic logic [RAW_W-1:0] pick_address();
    case ($urandom_range(3))
      0: return RAW_W'($urandom);
      1, 2: return RAW_W'($urandom_range(31));
      default: return RAW_W'(MEM_DEPTH - 1 - $urandom_range(31));
    endcase
  endfunction

  initial begin
    cpu.valid       = 1'b0;
    cpu.action      = ACT_READ;
    cpu.port_select = PORT_DATA;
    cpu.write_data  = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // lone control byte after reset acts as a second byte: address 0, write mode
    send_word(ACT_WRITE, PORT_CTRL, 8'h40);
    send_word(ACT_WRITE, PORT_DATA, 8'hff);
    send_word(ACT_WRITE, PORT_DATA, 8'h81);
    set_register(REG_MODE1, 8'h20);
    send_word(ACT_TICK, PORT_DATA, 8'h00);
    send_word(ACT_READ, PORT_CTRL, 8'h00);
    send_word(ACT_TICK, PORT_CTRL, 8'hff);
    set_register(REG_MODE1, 8'h00);
    send_word(ACT_TICK, PORT_DATA, 8'h00);
    set_register(REG_MODE1, 8'hff);
    set_address(14'h0000, 1'b0);
    send_word(ACT_READ, PORT_DATA, 8'h00);
    send_word(ACT_WRITE, PORT_DATA, 8'ha5);
    send_word(ACT_READ, PORT_DATA, 8'hff);
    set_address(14'h3fff, 1'b1);
    send_word(ACT_WRITE, PORT_DATA, 8'h5a);
    send_word(ACT_SPARE, PORT_CTRL, 8'hff);
    set_address(14'h3fff, 1'b0);
    send_word(ACT_READ, PORT_DATA, 8'h00);
    set_register(REG_LAST, 8'hff);
    drain();

    while (words_sent < TOTAL_WORDS) begin
      calm = (words_sent >= 250 && words_sent < 420);
      if (!held && words_sent >= 500) begin
        drain();
        held = 1'b1;
      end
      roll = $urandom_range(99);
      if (roll < 25) begin
        set_address(pick_address(), 1'($urandom_range(1)));
        data_burst();
      end else if (roll < 45) begin
        data_burst();
      end else if (roll < 60) begin
        if ($urandom_range(9) < 4) set_register(REG_MODE1, BYTE_W'($urandom));
        else set_register(REG_W'($urandom), BYTE_W'($urandom));
      end else if (roll < 70) begin
        send_word(ACT_TICK, 1'($urandom_range(1)), BYTE_W'($urandom));
      end else if (roll < 80) begin
        send_word(ACT_READ, PORT_CTRL, BYTE_W'($urandom));
      end else begin
        send_word(ACT_W'($urandom_range(3)), 1'($urandom_range(1)), BYTE_W'($urandom));
      end
    end
    calm = 1'b0;
    drain();
    repeat (8) @(negedge clk);

    $display("sent %0d words: %0d data reads, %0d status reads, %0d data writes,",
             words_sent, n_data_rd, n_status_rd, n_data_wr);
    $display("  %0d control writes, %0d frame ticks, %0d unused codes; %0d results checked",
             n_ctrl_wr, n_ticks, n_spare, results_seen);
    if (fail_count == 0 && pending == 0)
      $display("vdp_cpu_port_interface_core verification clean");
    else
      $display("vdp_cpu_port_interface_core verification failed");
    $finish;
  end

endmodule
